FILE: rtl/shbp_pkg.sv
// Shared types, constants and SHA-256 tables for the salted hash bin placement block.
package shbp_pkg;

    // Table geometry
    localparam int SLOTS   = 1024;
    localparam int ROWS    = 16;
    localparam int DIM_MAX = 8;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int TAB_W   = SLOT_W + ROW_W;
    localparam int DIM_W   = $clog2(DIM_MAX);

    // Message words: salt 42 as little-endian bytes, and the padding marker
    localparam logic [31:0] SALT_WORD = 32'h2A00_0000;
    localparam logic [31:0] PAD_WORD  = 32'h8000_0000;

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [63:0] elem_value;
        logic               elem_last;
        logic [9:0]         read_slot;
        logic [3:0]         read_row;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [9:0]         bin_index;
        logic signed [63:0] entry_value;
        logic [4:0]         max_fill;
    } out_item_t;

    typedef enum logic [1:0] {
        REG_RING_DIM = 2'd0,
        REG_DIM_ELEM = 2'd1,
        REG_MAX_BIN  = 2'd2,
        REG_DUMMY    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_COUNT  = 2'd2
    } stat_code_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FOLD,
        S_MOD_LOAD,
        S_MOD,
        S_FILL_RD,
        S_FILL_CHK,
        S_DECIDE,
        S_WRITE,
        S_READ
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       take_elem;
        logic       hash_start;
        logic       hash_step;
        logic       fold;
        logic       mod_start;
        logic       idx_clr;
        logic       fill_chk;
        logic       write_ent;
        logic       rd_issue;
        logic       clr_step;
        logic       emit;
        logic       emit_bin;
        logic       emit_read;
        stat_code_t emit_code;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_ok;
        logic no_bins;
        logic rnd_last;
        logic more_blk;
        logic div_busy;
        logic idx_last;
        logic ovf;
        logic clr_last;
    } dp_stat_t;

    function automatic logic [31:0] sha_iv(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sha_k(input logic [5:0] i);
        logic [31:0] r;
        case (i)
            6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/shbp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module shbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/shbp_ctrl.sv
// Controller state machine: sequences clearing, hashing, reduction, fill checks, writes and reads.
module shbp_ctrl
    import shbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     opcode,
    input  logic     elem_last,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_READ)
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        cmd.take_elem = 1'b1;
                        if (elem_last)
                        begin
                            if (!stat.count_ok)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_code = STAT_COUNT;
                            end
                            else if (stat.no_bins)
                            begin
                                cmd.emit      = 1'b1;
                                cmd.emit_code = STAT_REJECT;
                            end
                            else
                            begin
                                cmd.hash_start = 1'b1;
                                state_next     = S_HASH;
                            end
                        end
                    end
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.rnd_last)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = stat.more_blk ? S_HASH : S_MOD_LOAD;
            end
            S_MOD_LOAD:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                if (!stat.div_busy)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_FILL_RD;
                end
            end
            S_FILL_RD:
            begin
                state_next = S_FILL_CHK;
            end
            S_FILL_CHK:
            begin
                cmd.fill_chk = 1'b1;
                state_next   = stat.idx_last ? S_DECIDE : S_FILL_RD;
            end
            S_DECIDE:
            begin
                if (stat.ovf)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_bin  = 1'b1;
                    cmd.emit_code = STAT_REJECT;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_ent = 1'b1;
                if (stat.idx_last)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_bin  = 1'b1;
                    cmd.emit_code = STAT_OK;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_read = 1'b1;
                cmd.emit_code = STAT_OK;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    // Writes only follow a clean fill check
    a_write_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |-> !stat.ovf)
        else $error("table write after an overflow was found");

endmodule

FILE: rtl/shbp_dpath.sv
// Datapath: config registers, item buffer, SHA-256 round unit, divider, fill and table RAMs.
module shbp_dpath
    import shbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_data,
    input  in_item_t    item,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output logic        done,
    output out_item_t   result
);

    // Configuration
    logic [10:0] ring_dim_reg;
    logic [3:0]  dim_reg;
    logic [4:0]  max_bin_reg;
    logic [63:0] dummy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_dim_reg <= 11'd1024;
            dim_reg      <= 4'd1;
            max_bin_reg  <= 5'd16;
            dummy_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_RING_DIM: ring_dim_reg <= cfg_data[10:0];
                REG_DIM_ELEM: dim_reg      <= cfg_data[3:0];
                REG_MAX_BIN:  max_bin_reg  <= cfg_data[4:0];
                REG_DUMMY:    dummy_reg    <= cfg_data;
                default:      dummy_reg    <= dummy_reg;
            endcase
        end
    end

    logic [10:0] eff_ring;
    logic [4:0]  cap;
    logic        two_blk;

    assign eff_ring = (ring_dim_reg > 11'(SLOTS)) ? 11'(SLOTS) : ring_dim_reg;
    assign cap      = (max_bin_reg > 5'(ROWS)) ? 5'(ROWS) : max_bin_reg;
    // salt, elements and the 9 padding bytes spill into a second block above six elements
    assign two_blk  = (dim_reg > 4'd6);

    // Item buffer and element count
    logic [63:0] buf_reg [DIM_MAX];
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_plus;

    assign cnt_plus = (cnt_reg == 4'd15) ? 4'd15 : cnt_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.take_elem)
        begin
            cnt_reg <= item.elem_last ? 4'd0 : cnt_plus;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_elem && (cnt_reg < 4'(DIM_MAX)))
        begin
            buf_reg[cnt_reg[DIM_W-1:0]] <= item.elem_value;
        end
    end

    // SHA-256 round unit
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic        blk_reg;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Message word for the current round
    logic [4:0]  g;
    logic [4:0]  g_m1;
    logic [4:0]  two_d;
    logic [31:0] half_word;
    logic [63:0] elem_sel;
    logic [31:0] msg_word;
    logic [9:0]  bit_len;

    always_comb
    begin
        g         = {blk_reg, rnd_reg[3:0]};
        g_m1      = g - 5'd1;
        two_d     = {dim_reg, 1'b0};
        elem_sel  = buf_reg[g_m1[DIM_W:1]];
        half_word = g_m1[0] ? elem_sel[63:32] : elem_sel[31:0];
        bit_len   = {dim_reg, 6'b0} + 10'd32;
        if (g == 5'd0)
        begin
            msg_word = SALT_WORD;
        end
        else if (g <= two_d)
        begin
            msg_word = bswap(half_word);
        end
        else if (g == two_d + 5'd1)
        begin
            msg_word = PAD_WORD;
        end
        else if (g == (two_blk ? 5'd31 : 5'd15))
        begin
            msg_word = {22'b0, bit_len};
        end
        else
        begin
            msg_word = '0;
        end
    end

    // Schedule word and compression round
    logic [31:0] wt, t1, t2;
    logic [31:0] s0w, s1w, big0, big1, ch, maj;

    always_comb
    begin
        s0w  = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1w  = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wt   = (rnd_reg < 6'd16) ? msg_word : (s1w + w_reg[9] + s0w + w_reg[0]);
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + big1 + ch + sha_k(rnd_reg) + wt;
        t2   = big0 + maj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg <= '0;
            blk_reg <= 1'b0;
        end
        else if (cmd.hash_start)
        begin
            rnd_reg <= '0;
            blk_reg <= 1'b0;
        end
        else if (cmd.hash_step)
        begin
            rnd_reg <= rnd_reg + 6'd1;
        end
        else if (cmd.fold)
        begin
            rnd_reg <= '0;
            blk_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash_start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_iv(3'(i));
                v_reg[i] <= sha_iv(3'(i));
            end
        end
        else if (cmd.hash_step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wt;
        end
        else if (cmd.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
                v_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    // Shared restoring divider: bin count first, then digest mod bin count
    logic [63:0] dvd_reg;
    logic [9:0]  rem_reg;
    logic [10:0] dvs_reg;
    logic [5:0]  dcnt_reg;
    logic        div_busy_reg;
    logic        div_mod_reg;
    logic [10:0] bins_reg;
    logic [9:0]  bin_reg;
    logic [10:0] cand;
    logic        qbit;
    logic [9:0]  rem_step;
    logic [63:0] dvd_step;

    always_comb
    begin
        cand     = {rem_reg, dvd_reg[63]};
        qbit     = (cand >= dvs_reg);
        rem_step = qbit ? 10'(cand - dvs_reg) : cand[9:0];
        dvd_step = {dvd_reg[62:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_mod_reg  <= 1'b0;
            dcnt_reg     <= '0;
        end
        else if (cmd.hash_start || cmd.mod_start)
        begin
            div_busy_reg <= 1'b1;
            div_mod_reg  <= cmd.mod_start;
            dcnt_reg     <= '0;
        end
        else if (div_busy_reg)
        begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (dcnt_reg == 6'd63)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hash_start)
        begin
            dvd_reg <= {53'b0, eff_ring};
            rem_reg <= '0;
            dvs_reg <= {7'b0, dim_reg};
        end
        else if (cmd.mod_start)
        begin
            dvd_reg <= {bswap(h_reg[1]), bswap(h_reg[0])};
            rem_reg <= '0;
            dvs_reg <= bins_reg;
        end
        else if (div_busy_reg)
        begin
            dvd_reg <= dvd_step;
            rem_reg <= rem_step;
            if (dcnt_reg == 6'd63)
            begin
                if (div_mod_reg)
                begin
                    bin_reg <= rem_step;
                end
                else
                begin
                    bins_reg <= dvd_step[10:0];
                end
            end
        end
    end

    // Slot walk over the item's elements
    logic [SLOT_W-1:0] base_reg;
    logic [3:0]        idx_reg;
    logic [4:0]        fills_reg [DIM_MAX];
    logic              ovf_reg;
    logic [SLOT_W-1:0] slot_addr;
    logic [4:0]        fill_cur;
    logic [4:0]        fill_inc;
    logic [4:0]        fill_q;
    logic [13:0]       base_prod;

    assign base_prod = 14'(bin_reg) * 14'(dim_reg);
    assign slot_addr = SLOT_W'(base_reg + SLOT_W'(idx_reg));
    assign fill_cur  = fills_reg[idx_reg[DIM_W-1:0]];
    assign fill_inc  = fill_cur + 5'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mod_start)
            begin
                ovf_reg <= 1'b0;
            end
            else if (cmd.fill_chk && (fill_q >= cap))
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.fill_chk || cmd.write_ent)
            begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.idx_clr)
        begin
            base_reg <= base_prod[SLOT_W-1:0];
        end
        if (cmd.fill_chk)
        begin
            fills_reg[idx_reg[DIM_W-1:0]] <= fill_q;
        end
    end

    // Clearing pass over the fill counts after reset
    logic [SLOT_W-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
        end
    end

    // Fill count and table memories
    logic [TAB_W-1:0] tab_waddr;
    logic [63:0]      tab_q;

    assign tab_waddr = {slot_addr, fill_cur[ROW_W-1:0]};

    shbp_ram #(
        .WIDTH (5),
        .DEPTH (SLOTS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (cmd.clr_step || cmd.write_ent),
        .waddr (cmd.clr_step ? clr_addr_reg : slot_addr),
        .wdata (cmd.clr_step ? 5'd0 : fill_inc),
        .raddr (cmd.rd_issue ? item.read_slot : slot_addr),
        .rdata (fill_q)
    );

    shbp_ram #(
        .WIDTH (64),
        .DEPTH (SLOTS * ROWS)
    ) u_table_ram (
        .clk   (clk),
        .we    (cmd.write_ent),
        .waddr (tab_waddr),
        .wdata (buf_reg[idx_reg[DIM_W-1:0]]),
        .raddr ({item.read_slot, item.read_row}),
        .rdata (tab_q)
    );

    // Read access bookkeeping
    logic       rd_dummy_reg;
    logic [3:0] rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_dummy_reg <= ({1'b0, item.read_slot} >= eff_ring);
            rd_row_reg   <= item.read_row;
        end
    end

    // Largest fill and result register
    logic [4:0] largest_reg;
    logic [4:0] largest_next;
    logic       done_reg;
    out_item_t  res_reg;

    assign largest_next = (cmd.write_ent && (fill_inc > largest_reg)) ? fill_inc : largest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            largest_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            largest_reg <= largest_next;
            done_reg    <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg.status    <= cmd.emit_code;
            res_reg.bin_index <= cmd.emit_bin ? bin_reg : 10'd0;
            res_reg.max_fill  <= largest_next;
            if (cmd.emit_read)
            begin
                res_reg.entry_value <= (rd_dummy_reg || ({1'b0, rd_row_reg} >= fill_q))
                                       ? dummy_reg : tab_q;
            end
            else
            begin
                res_reg.entry_value <= '0;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    // Status to the controller
    always_comb
    begin
        stat.count_ok = (dim_reg != 4'd0) && (dim_reg <= 4'(DIM_MAX)) && (cnt_plus == dim_reg);
        stat.no_bins  = (eff_ring < {7'b0, dim_reg});
        stat.rnd_last = (rnd_reg == 6'd63);
        stat.more_blk = two_blk && !blk_reg;
        stat.div_busy = div_busy_reg;
        stat.idx_last = ((idx_reg + 4'd1) == dim_reg);
        stat.ovf      = ovf_reg;
        stat.clr_last = (clr_addr_reg == SLOT_W'(SLOTS - 1));
    end

    // Bin count division must be done before the reduction reuses the divider
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mod_start |-> !div_busy_reg)
        else $error("divider still busy at reduction start");

    // A write never lands in a full slot
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_ent |-> (fill_cur < cap))
        else $error("write into a full slot");

    // The last element always restarts the element count
    a_cnt_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_elem && item.elem_last) |=> (cnt_reg == 4'd0))
        else $error("element count not restarted after last element");

endmodule

FILE: rtl/salted_hash_bin_placement.sv
// Top level of the salted hash bin placement block: controller plus datapath.
//
// After reset the block clears its 1024 slot fill counts, one per cycle, and holds busy
// high while it clears them; configuration writes are taken at any time. An item is
// accepted when start is high and busy is low. An insert element that is not the last
// is buffered and gives no result. A read issues its RAM read, then registers the result.
// A last element with a bad count or no bins gives its result in the next cycle.
// Otherwise the SHA-256 unit runs one round per cycle, a hash state then a fold state per
// block (one block for up to six elements, two for seven or eight), a 64-step divider
// then reduces the digest, each element is fill checked in the fill read and fill check
// states, and then each element is written in the write state. The result shows on result
// for one cycle with done high, and must be taken then: the receiver cannot stall the block.
module salted_hash_bin_placement
    import shbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        done,
    output out_item_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    shbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (item.opcode),
        .elem_last (item.elem_last),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    shbp_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule
